// ----- design/skl_pkg.sv -----
`default_nettype none
package skl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int MODE_W   = 3;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int STAT_W   = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    localparam int S_FIELDS_W = MODE_W + KEY_W + PAY_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STAT_W + POS_W + 1 + COUNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic out_stall;
    } t_sts;

endpackage
`default_nettype wire

// ----- design/skl_ctrl.sv -----
`default_nettype none
module skl_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire skl_pkg::t_sts i_sts,
    output skl_pkg::t_cmd     o_cmd
);
    import skl_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state     = r_state;
        o_s_tready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.capture = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = !i_sts.out_stall;
                if (!i_sts.out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ----- design/skl_datapath.sv -----
`default_nettype none
module skl_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire skl_pkg::t_cmd                 i_cmd,
    input  wire logic [skl_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  wire logic                          i_m_tready,
    output logic                               o_m_tvalid,
    output logic [skl_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output skl_pkg::t_sts                      o_sts
);
    import skl_pkg::*;

    logic [KEY_W-1:0]   r_key [CAPACITY];
    logic [PAY_W-1:0]   r_pay [CAPACITY];
    logic [KEY_W-1:0]   n_key [CAPACITY];
    logic [PAY_W-1:0]   n_pay [CAPACITY];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    logic [MODE_W-1:0]  r_mode;
    logic [KEY_W-1:0]   r_req_key;
    logic [PAY_W-1:0]   r_req_pay;
    logic [CAPACITY-1:0] r_match;
    logic [CAPACITY-1:0] r_less;
    logic [CAPACITY-1:0] n_match;
    logic [CAPACITY-1:0] n_less;
    logic [CAPACITY-1:0] valid;

    logic [MODE_W-1:0]  in_mode;
    logic [KEY_W-1:0]   in_key;
    logic [PAY_W-1:0]   in_pay;

    logic [IDX_W-1:0]   where_idx;
    logic [IDX_W-1:0]   ins_idx;
    logic [IDX_W-1:0]   new_idx;
    logic               found;
    logic               full;
    logic               shift_up;
    logic               shift_dn;
    logic               wr_new;

    logic [STAT_W-1:0]  res_stat;
    logic [IDX_W-1:0]   res_pos;
    logic               res_found;
    logic [IDX_W+POS_W-1:0]   pos_ext;
    logic [CNT_W+COUNT_W-1:0] cnt_ext;

    logic               r_out_valid;
    logic [M_TDATA_W-1:0] r_out_tdata;

    assign in_mode = i_s_tdata[MODE_W-1:0];
    assign in_key  = i_s_tdata[MODE_W+KEY_W-1:MODE_W];
    assign in_pay  = i_s_tdata[MODE_W+KEY_W+PAY_W-1:MODE_W+KEY_W];

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            valid[i]   = CNT_W'(i) < r_count;
            n_match[i] = valid[i] && (r_key[i] == in_key);
            n_less[i]  = valid[i] && ($signed(r_key[i]) < $signed(in_key));
        end
    end

    always_comb begin
        where_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_match[i]) begin
                where_idx = IDX_W'(i);
            end
        end
        ins_idx = IDX_W'(r_count);
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (valid[i] && !r_less[i]) begin
                ins_idx = IDX_W'(i);
            end
        end
    end

    assign found = |r_match;
    assign full  = r_count >= CNT_W'(CAPACITY);

    always_comb begin
        res_stat  = STAT_OK;
        res_pos   = '0;
        res_found = found;
        n_count   = r_count;
        new_idx   = IDX_W'(r_count);
        shift_up  = 1'b0;
        shift_dn  = 1'b0;
        wr_new    = 1'b0;
        case (r_mode)
            MODE_APPEND, MODE_INSERT: begin
                if (full) begin
                    res_stat = STAT_FULL;
                end else if (found) begin
                    res_stat = STAT_DUPLICATE;
                    res_pos  = where_idx;
                end else begin
                    if (r_mode == MODE_INSERT) begin
                        new_idx  = ins_idx;
                        shift_up = 1'b1;
                    end
                    wr_new  = 1'b1;
                    n_count = r_count + 1'b1;
                    res_pos = new_idx;
                end
            end
            MODE_REMOVE: begin
                if (!found) begin
                    res_stat = STAT_NOT_FOUND;
                end else begin
                    shift_dn = 1'b1;
                    n_count  = r_count - 1'b1;
                    res_pos  = where_idx;
                end
            end
            MODE_LOOKUP: begin
                if (!found) begin
                    res_stat = STAT_NOT_FOUND;
                end else begin
                    res_pos = where_idx;
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                res_found = 1'b0;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_key[i] = r_key[i];
            n_pay[i] = r_pay[i];
        end
        for (int i = 1; i < CAPACITY; i++) begin
            if (shift_up && (IDX_W'(i) > new_idx) && (CNT_W'(i) <= r_count)) begin
                n_key[i] = r_key[i-1];
                n_pay[i] = r_pay[i-1];
            end
        end
        for (int i = 0; i < CAPACITY - 1; i++) begin
            if (shift_dn && (IDX_W'(i) >= where_idx) && (CNT_W'(i + 1) < r_count)) begin
                n_key[i] = r_key[i+1];
                n_pay[i] = r_pay[i+1];
            end
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (wr_new && (IDX_W'(i) == new_idx)) begin
                n_key[i] = r_req_key;
                n_pay[i] = r_req_pay;
            end
        end
    end

    assign pos_ext = {{POS_W{1'b0}}, res_pos};
    assign cnt_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= in_mode;
            r_req_key <= in_key;
            r_req_pay <= in_pay;
            r_match   <= n_match;
            r_less    <= n_less;
        end
        if (i_cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_key[i] <= n_key[i];
                r_pay[i] <= n_pay[i];
            end
            r_out_tdata <= M_TDATA_W'({cnt_ext[COUNT_W-1:0], res_found,
                                       pos_ext[POS_W-1:0], res_stat});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = r_out_tdata;
    assign o_sts.out_stall = r_out_valid && !i_m_tready;

endmodule
`default_nettype wire

// ----- design/sorted_keyed_list_table.sv -----
// A request is taken into the capture registers while the controller is idle;
// in the execute state it is applied to the entry registers and its result is
// registered, and no new request is taken until the controller is idle again.
// A result held on the master side stalls the update until it is taken.
// Reset clears the entry count and the handshake state; stored keys and
// payload words are not cleared and are only read below the entry count.
`default_nettype none
module sorted_keyed_list_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // Fields from bit 0: mode[2:0], key[34:3], payload[66:35], zero pad.
    input  wire logic [skl_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // Fields from bit 0: status[1:0], position[5:2], found[6], count[11:7], zero pad.
    output logic [skl_pkg::M_TDATA_W-1:0]      o_m_tdata
);
    import skl_pkg::*;

    t_cmd cmd;
    t_sts sts;

    skl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    skl_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_sts      (sts)
    );

    a_capture_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> !o_s_tready)
        else $error("request taken while another was in flight");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> o_m_tvalid)
        else $error("update did not present a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> !(o_m_tvalid && !i_m_tready))
        else $error("result overwritten while stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[11:7] <= 5'(CAPACITY)))
        else $error("entry count beyond capacity");

endmodule
`default_nettype wire
